>>> design/swma_pkg.sv
package swma_pkg;

    // Parameter defaults
    localparam int WINDOW_MAX_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int LEN_BITS       = 11;
    localparam int SUM_OUT_BITS   = 26;
    localparam int AVG_OUT_BITS   = 24;
    localparam int OUT_TDATA_BITS = ((SUM_OUT_BITS + AVG_OUT_BITS + 7) / 8) * 8;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1);

    // End-of-sequence status passed between stages
    typedef struct packed {
        logic valid;
        logic too_short;
    } swma_done_t;

endpackage

>>> design/swma_delay_line.sv
module swma_delay_line #(
    parameter int DEPTH = swma_pkg::WINDOW_MAX_DEF,
    parameter int WIDTH = swma_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    import swma_pkg::*;

    logic [WIDTH-1:0] ram [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: the read returns the entry that the same write replaces
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= ram[addr];
            ram[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/swma_window.sv
module swma_window #(
    parameter int WINDOW_MAX  = swma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swma_pkg::SAMPLE_BITS_DEF,
    parameter int KW          = $clog2(WINDOW_MAX + 1),
    parameter int SW          = SAMPLE_BITS + KW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic [KW-1:0]                 win_len,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output swma_pkg::swma_done_t          done,
    output logic signed [SW-1:0]          best_sum
);
    import swma_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);

    logic [KW-1:0] seen_reg, seen_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [KW-1:0] seen_inc, wp_inc;
    logic          full_now;

    logic                          p1_valid_reg, p1_last_reg;
    logic                          p1_full_reg, p1_first_reg, p1_short_reg;
    logic signed [SAMPLE_BITS-1:0] p1_sample_reg;
    logic [SAMPLE_BITS-1:0]        old_raw;
    logic signed [SAMPLE_BITS-1:0] old_sample;

    logic                 p2_valid_reg, p2_last_reg;
    logic                 p2_full_reg, p2_first_reg, p2_short_reg;
    logic signed [SW-1:0] ws_reg, ws_next;
    logic signed [SW-1:0] best_reg;
    swma_done_t           done_reg;

    swma_delay_line #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_line (
        .clk   (clk),
        .en    (in_valid),
        .addr  (wp_reg),
        .wdata (in_sample),
        .rdata (old_raw)
    );

    assign old_sample = $signed(old_raw);
    assign seen_inc   = seen_reg + KW'(1);
    assign wp_inc     = KW'(wp_reg) + KW'(1);
    assign full_now   = (seen_reg == win_len);

    always_comb
    begin
        seen_next = seen_reg;
        wp_next   = wp_reg;
        if (in_valid)
        begin
            if (in_last)
            begin
                seen_next = '0;
                wp_next   = '0;
            end
            else
            begin
                seen_next = full_now ? seen_reg : seen_inc;
                wp_next   = (wp_inc >= win_len) ? '0 : wp_inc[AW-1:0];
            end
        end
    end

    // Add the new sample, drop the one leaving the window once it is full
    assign ws_next = ws_reg + SW'(p1_sample_reg) - (p1_full_reg ? SW'(old_sample) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            wp_reg       <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            ws_reg       <= '0;
            best_reg     <= '0;
            done_reg     <= '0;
        end
        else if (clear)
        begin
            seen_reg     <= '0;
            wp_reg       <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            ws_reg       <= '0;
            best_reg     <= '0;
            done_reg     <= '0;
        end
        else
        begin
            seen_reg     <= seen_next;
            wp_reg       <= wp_next;
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;

            if (done_reg.valid)
            begin
                ws_reg   <= '0;
                best_reg <= '0;
            end
            else
            begin
                if (p1_valid_reg)
                    ws_reg <= ws_next;
                if (p2_valid_reg)
                begin
                    if (p2_first_reg)
                        best_reg <= ws_reg;
                    else if (p2_full_reg && (ws_reg > best_reg))
                        best_reg <= ws_reg;
                end
            end

            done_reg.valid     <= p2_valid_reg && p2_last_reg;
            done_reg.too_short <= p2_short_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            p1_sample_reg <= in_sample;
            p1_last_reg   <= in_last;
            p1_full_reg   <= full_now;
            p1_first_reg  <= !full_now && (seen_inc == win_len);
            p1_short_reg  <= !full_now && (seen_inc != win_len);
        end
        if (p1_valid_reg)
        begin
            p2_last_reg  <= p1_last_reg;
            p2_full_reg  <= p1_full_reg;
            p2_first_reg <= p1_first_reg;
            p2_short_reg <= p1_short_reg;
        end
    end

    assign done     = done_reg;
    assign best_sum = best_reg;

endmodule

>>> design/swma_divider.sv
module swma_divider #(
    parameter int FRACTION_BITS = swma_pkg::FRACTION_BITS_DEF,
    parameter int KW            = 11,
    parameter int SW            = 27
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swma_pkg::swma_done_t                  start,
    input  logic signed [SW-1:0]                  dividend,
    input  logic [KW-1:0]                         divisor,
    input  logic                                  ack,
    output swma_pkg::swma_done_t                  res,
    output logic [swma_pkg::SUM_OUT_BITS-1:0]     sum_out,
    output logic [swma_pkg::AVG_OUT_BITS-1:0]     avg_out
);
    import swma_pkg::*;

    localparam int DW    = SW + FRACTION_BITS;
    localparam int QW    = DW + 1;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int ACW   = ((QW > AVG_OUT_BITS) ? QW : AVG_OUT_BITS) + 1;
    localparam int SCW   = ((SW > SUM_OUT_BITS) ? SW : SUM_OUT_BITS) + 1;

    localparam logic signed [ACW-1:0] AVG_HI = ACW'(2 ** (AVG_OUT_BITS - 1) - 1);
    localparam logic signed [ACW-1:0] AVG_LO = -AVG_HI - ACW'(1);
    localparam logic signed [SCW-1:0] SUM_HI = SCW'(2 ** (SUM_OUT_BITS - 1) - 1);
    localparam logic signed [SCW-1:0] SUM_LO = -SUM_HI - SCW'(1);

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_RUN  = 4'b0010,
        DV_FIX  = 4'b0100,
        DV_DONE = 4'b1000
    } dv_state_t;

    dv_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg;
    logic [DW-1:0]            quo_reg;
    logic [KW-1:0]            rem_reg;
    logic [KW-1:0]            div_reg;
    logic                     neg_reg;
    logic                     short_reg;
    logic signed [SW-1:0]     sum_reg;
    logic [SUM_OUT_BITS-1:0]  sum_out_reg;
    logic [AVG_OUT_BITS-1:0]  avg_out_reg;

    logic [SW-1:0]            mag;
    logic [KW:0]              shifted;
    logic                     fits;
    logic signed [QW-1:0]     q_s;
    logic signed [ACW-1:0]    q_ext;
    logic signed [SCW-1:0]    s_ext;

    assign mag     = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits    = (shifted >= {1'b0, div_reg});
    assign q_s     = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign q_ext   = ACW'(q_s);
    assign s_ext   = SCW'(sum_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start.valid)
                    state_next = start.too_short ? DV_DONE : DV_RUN;
            end
            DV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = DV_FIX;
            end
            DV_FIX:  state_next = DV_DONE;
            DV_DONE:
            begin
                if (ack)
                    state_next = DV_IDLE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (start.valid)
                begin
                    short_reg   <= start.too_short;
                    neg_reg     <= dividend[SW-1];
                    sum_reg     <= dividend;
                    quo_reg     <= DW'(mag) << FRACTION_BITS;
                    rem_reg     <= '0;
                    div_reg     <= divisor;
                    cnt_reg     <= CNT_W'(DW);
                    sum_out_reg <= '0;
                    avg_out_reg <= '0;
                end
            end
            DV_RUN:
            begin
                // One quotient bit per cycle, restoring
                rem_reg <= fits ? KW'(shifted - {1'b0, div_reg}) : shifted[KW-1:0];
                quo_reg <= {quo_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            DV_FIX:
            begin
                if (q_ext > AVG_HI)
                    avg_out_reg <= AVG_HI[AVG_OUT_BITS-1:0];
                else if (q_ext < AVG_LO)
                    avg_out_reg <= AVG_LO[AVG_OUT_BITS-1:0];
                else
                    avg_out_reg <= q_ext[AVG_OUT_BITS-1:0];

                if (s_ext > SUM_HI)
                    sum_out_reg <= SUM_HI[SUM_OUT_BITS-1:0];
                else if (s_ext < SUM_LO)
                    sum_out_reg <= SUM_LO[SUM_OUT_BITS-1:0];
                else
                    sum_out_reg <= s_ext[SUM_OUT_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid     = (state_reg == DV_DONE);
    assign res.too_short = short_reg;
    assign sum_out       = sum_out_reg;
    assign avg_out       = avg_out_reg;

endmodule

>>> design/sliding_window_max_average.sv
// Result path: the window pipeline feeds a bit-serial divider that forms a DW-bit quotient,
//   DW = SAMPLE_BITS + clog2(WINDOW_MAX + 1) + FRACTION_BITS; a short sequence skips the
//   division and is passed on with zero values.
// Throughput: one sample per cycle within a sequence; after a last sample the input stalls
//   until that result reaches the output register.
// Reset: asynchronous, active low; window length returns to 1 and all sequence state clears.
module sliding_window_max_average #(
    parameter int WINDOW_MAX    = swma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = swma_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = swma_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [swma_pkg::LEN_BITS-1:0]          cfg_wr_data,   // window_length
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
    input  logic                                   s_axis_tlast,  // last_sample
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [swma_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,  // max_window_sum, max_average
    output logic                                   m_axis_tuser   // too_short
);
    import swma_pkg::*;

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int SW = SAMPLE_BITS + KW;

    logic [KW-1:0]             win_len_reg;
    logic [KW-1:0]             win_len_next;
    logic                      busy_reg;
    logic                      m_valid_reg;
    logic [OUT_TDATA_BITS-1:0] m_data_reg;
    logic                      m_user_reg;

    logic                      s_xfer;
    logic                      load;
    swma_done_t                win_done;
    swma_done_t                div_res;
    logic signed [SW-1:0]      best_sum;
    logic [SUM_OUT_BITS-1:0]   sum_out;
    logic [AVG_OUT_BITS-1:0]   avg_out;

    assign s_axis_tready = !busy_reg;
    assign s_xfer        = s_axis_tvalid && !busy_reg;
    assign load          = div_res.valid && (!m_valid_reg || m_axis_tready);

    // Zero means one, anything past the delay line depth means the full depth
    always_comb
    begin
        if (cfg_wr_data == '0)
            win_len_next = KW'(1);
        else if (32'(cfg_wr_data) > WINDOW_MAX)
            win_len_next = KW'(WINDOW_MAX);
        else
            win_len_next = KW'(cfg_wr_data);
    end

    swma_window #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .KW          (KW),
        .SW          (SW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_wr_en),
        .win_len   (win_len_reg),
        .in_valid  (s_xfer),
        .in_sample ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .in_last   (s_axis_tlast),
        .done      (win_done),
        .best_sum  (best_sum)
    );

    swma_divider #(
        .FRACTION_BITS (FRACTION_BITS),
        .KW            (KW),
        .SW            (SW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (win_done),
        .dividend (best_sum),
        .divisor  (win_len_reg),
        .ack      (load),
        .res      (div_res),
        .sum_out  (sum_out),
        .avg_out  (avg_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= KW'(LEN_RESET);
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                win_len_reg <= win_len_next;

            // Hold input off from a last transfer until its result is loaded
            if (s_xfer && s_axis_tlast)
                busy_reg <= 1'b1;
            else if (load)
                busy_reg <= 1'b0;

            if (load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= OUT_TDATA_BITS'({avg_out, sum_out});
            m_user_reg <= div_res.too_short;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

>>> design/swma_checker.sv
module swma_checker #(
    parameter int SAMPLE_BITS = swma_pkg::SAMPLE_BITS_DEF
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic                                   s_axis_tlast,
    input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [swma_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    input logic                                   m_axis_tuser
);
    import swma_pkg::*;

    // Input stalls right after the last sample of a sequence transfers
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready after last sample transfer");

    // A new result only appears while the input was stalled
    a_result_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a preceding last sample");

    // A short sequence reports zero values
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("short-sequence result carries nonzero data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An offered sample holds until it transfers
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("offered sample changed before transfer");

endmodule

bind sliding_window_max_average swma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/sliding_window_max_average_tb.sv
module sliding_window_max_average_tb;
    import swma_pkg::*;

    typedef struct {
        logic signed [SUM_OUT_BITS-1:0] max_sum;
        logic signed [AVG_OUT_BITS-1:0] max_avg;
        logic                           too_short;
    } seq_result_t;

    class swma_scoreboard;
        int                 window;
        logic signed [15:0] taps [WINDOW_MAX_DEF];
        longint             run_sum;
        longint             best_sum;
        int                 filled;
        int                 wr_ptr;
        seq_result_t        expected_q [$];
        int                 errors;
        int                 samples;
        int                 results;
        int                 short_results;

        function new();
            window = 1;
            restart_sequence();
        endfunction

        function void restart_sequence();
            run_sum = 0;
            best_sum = 0;
            filled = 0;
            wr_ptr = 0;
        endfunction

        function void set_length(logic [LEN_BITS-1:0] value);
            if (value == 0)
                window = 1;
            else if (value > WINDOW_MAX_DEF)
                window = WINDOW_MAX_DEF;
            else
                window = int'(value);
            restart_sequence();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic signed [15:0] x, bit last_flag);
            seq_result_t r;
            samples++;
            if (filled < window) begin
                run_sum += longint'(x);
                taps[wr_ptr] = x;
                filled++;
                if (filled == window)
                    best_sum = run_sum;
            end
            else begin
                run_sum += longint'(x) - longint'(taps[wr_ptr]);
                taps[wr_ptr] = x;
                if (run_sum > best_sum)
                    best_sum = run_sum;
            end
            wr_ptr = (wr_ptr + 1 == window) ? 0 : wr_ptr + 1;
            if (last_flag) begin
                if (filled < window) begin
                    r.max_sum = '0;
                    r.max_avg = '0;
                    r.too_short = 1'b1;
                end
                else begin
                    // truncates toward zero, as the block does
                    r.max_sum = SUM_OUT_BITS'(best_sum);
                    r.max_avg = AVG_OUT_BITS'((best_sum * (longint'(1) << FRACTION_BITS_DEF))
                                              / window);
                    r.too_short = 1'b0;
                end
                expected_q.push_back(r);
                restart_sequence();
            end
        endfunction

        function void check_result(logic [OUT_TDATA_BITS-1:0] data, logic flag);
            seq_result_t e;
            logic signed [SUM_OUT_BITS-1:0] got_sum;
            logic signed [AVG_OUT_BITS-1:0] got_avg;
            got_sum = data[SUM_OUT_BITS-1:0];
            got_avg = data[SUM_OUT_BITS +: AVG_OUT_BITS];
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: sum %0d avg %0d too_short %b",
                         $time, got_sum, got_avg, flag);
                return;
            end
            e = expected_q.pop_front();
            results++;
            if (e.too_short)
                short_results++;
            if (got_sum !== e.max_sum) begin
                errors++;
                $display("%0t: max_window_sum expected %0d actual %0d",
                         $time, e.max_sum, got_sum);
            end
            if (got_avg !== e.max_avg) begin
                errors++;
                $display("%0t: max_average expected %0d actual %0d",
                         $time, e.max_avg, got_avg);
            end
            if (flag !== e.too_short) begin
                errors++;
                $display("%0t: too_short expected %b actual %b", $time, e.too_short, flag);
            end
        endfunction
    endclass

    localparam int PHASE_LEN [9] = '{2, 3, 5, 7, 16, 40, 1, 6, 4};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [LEN_BITS-1:0]       cfg_wr_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [15:0]               s_axis_tdata = '0;   // sample
    logic                      s_axis_tlast = 1'b0; // last_sample
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // max_window_sum, max_average
    logic                      m_axis_tuser;        // too_short

    swma_scoreboard sb;
    bit             tx_gaps = 1'b1;
    bit             rx_gaps = 1'b1;
    bit             hold_req = 1'b0;
    int             settings;

    always #2 clk = ~clk;

    sliding_window_max_average uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic logic signed [15:0] draw_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        else if (pick < 50)
            return 16'($signed($urandom_range(200)) - 100);
        else
            return 16'($urandom);
    endfunction

    task automatic put_sample(input logic signed [15:0] x, input bit last_flag);
        while (tx_gaps && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        s_axis_tlast <= last_flag;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_input(x, last_flag);
    endtask

    task automatic send_sequence(input int count, input bit close);
        for (int i = 0; i < count; i++)
            put_sample(draw_sample(), close && (i == count - 1));
    endtask

    // Drop valid, drain every expected result, then allow for the divider.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_window(input logic [LEN_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_length(value);
        settings++;
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin : sink
        int hold_cycles;
        hold_cycles = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cycles = 400;
            end
            if (hold_cycles > 0)
                hold_cycles--;
            m_axis_tready <= (hold_cycles == 0) && (!rx_gaps || $urandom_range(99) >= 34);
        end
    end

    initial begin : stimulus
        int k;
        int n;
        int sent;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one after reset: extremes and a mixed run
        put_sample(16'sh7FFF, 1'b1);
        put_sample(16'sh8000, 1'b1);
        put_sample(16'sh0000, 1'b1);
        put_sample(-16'sd1, 1'b0);
        put_sample(16'sd1, 1'b0);
        put_sample(16'sd100, 1'b0);
        put_sample(-16'sd5, 1'b1);
        settle();
        write_window(11'd3);
        put_sample(16'sd5, 1'b0);
        put_sample(16'sd6, 1'b1);
        // negative average truncates toward zero
        put_sample(-16'sd1, 1'b0);
        put_sample(16'sd0, 1'b0);
        put_sample(16'sd0, 1'b1);
        // abandon a sequence, then change the length under it
        put_sample(16'sd7, 1'b0);
        put_sample(16'sd8, 1'b0);
        settle();
        write_window(11'd0);
        put_sample(-16'sd7, 1'b0);
        put_sample(-16'sd3, 1'b1);

        for (int p = 0; p < 9; p++) begin
            settle();
            k = (p == 7) ? $urandom_range(1, 12) : PHASE_LEN[p];
            write_window(LEN_BITS'(k));
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < 60) begin
                if (k > 1 && $urandom_range(99) < 15)
                    n = $urandom_range(1, k - 1);
                else
                    n = k + $urandom_range(0, 2 * k + 3);
                send_sequence(n, 1'b1);
                sent += n;
            end
            // leave a broken sequence behind for the next write to clear
            if (p % 2 == 1)
                send_sequence($urandom_range(1, k + 2), 1'b0);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // oversized lengths clamp to the full depth, so three samples fall short
        settle();
        write_window(11'd2047);
        send_sequence(3, 1'b1);
        settle();
        write_window(11'd1025);
        send_sequence(3, 1'b1);
        // long windows at both ends of the sample range
        settle();
        write_window(11'd100);
        for (int i = 0; i < 100; i++)
            put_sample(16'sh7FFF, i == 99);
        for (int i = 0; i < 110; i++)
            put_sample(16'sh8000, i == 109);

        settle();
        $display("Covered %0d samples and %0d sequence results (%0d too short)",
                 sb.samples, sb.results, sb.short_results);
        $display("over %0d window settings, with stalls, a long output hold-off and no-gap runs",
                 settings);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #1600000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
